>>> design/ais_pkg.sv
// ----------------------------------------------------------------------------
// ais_pkg
// Types and constants shared by the ASCII integer scanner modules.
// ----------------------------------------------------------------------------
package ais_pkg;

    localparam int VALUE_BITS    = 64;
    localparam int CONSUMED_BITS = 16;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);

    // configuration register indexes
    localparam logic [1:0] REG_HEX_MODE    = 2'd0;
    localparam logic [1:0] REG_SIGNED_MODE = 2'd1;
    localparam logic [1:0] REG_WIDTH_MODE  = 2'd2;

    // output width modes
    localparam logic [1:0] WIDTH_FULL   = 2'd0;
    localparam logic [1:0] WIDTH_TRUNC32 = 2'd1;
    localparam logic [1:0] WIDTH_TRUNC16 = 2'd2;
    localparam logic [1:0] WIDTH_SAT32  = 2'd3;

    // character codes
    localparam logic [7:0] CHAR_NUL     = 8'd0;
    localparam logic [7:0] CHAR_MINUS   = 8'd45;
    localparam logic [7:0] CHAR_ZERO    = 8'd48;
    localparam logic [7:0] CHAR_NINE    = 8'd57;
    localparam logic [7:0] CHAR_UPPER_A = 8'd65;
    localparam logic [7:0] CHAR_UPPER_F = 8'd70;
    localparam logic [7:0] CHAR_LOWER_A = 8'd97;
    localparam logic [7:0] CHAR_LOWER_F = 8'd102;

    typedef logic [1:0] char_class_t;
    localparam char_class_t CLASS_TERM    = 2'd0;
    localparam char_class_t CLASS_DIGIT   = 2'd1;
    localparam char_class_t CLASS_MINUS   = 2'd2;
    localparam char_class_t CLASS_INVALID = 2'd3;

    typedef struct packed {
        logic       hex_mode;
        logic       signed_mode;
        logic [1:0] width_mode;
    } cfg_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       start_of_string;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0]    value;
        logic [CONSUMED_BITS-1:0] consumed;
        logic                     finished;
    } out_item_t;

    typedef struct packed {
        logic        start;
        char_class_t cls;
        logic [3:0]  digit;
    } qitem_t;

endpackage

>>> design/ais_front.sv
// ----------------------------------------------------------------------------
// ais_front
// Accepts characters, classifies them and registers the request for the queue.
// ----------------------------------------------------------------------------
module ais_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  ais_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_stall,
    input  ais_pkg::in_item_t in_data,
    output logic              push_valid,
    input  logic              push_stall,
    output ais_pkg::qitem_t   push_item
);

    logic            valid_reg;
    ais_pkg::qitem_t item_reg;
    ais_pkg::qitem_t item_next;
    logic [7:0]      c;
    logic [7:0]      dec_val;
    logic [7:0]      hex_val;

    assign c       = in_data.char_code;
    assign dec_val = c - ais_pkg::CHAR_ZERO;
    assign hex_val = c - ais_pkg::CHAR_UPPER_A + 8'd10;   // low nibble also fits 'a'..'f'

    always_comb
    begin
        item_next.start = in_data.start_of_string;
        item_next.digit = 4'd0;
        if (c == ais_pkg::CHAR_NUL)
        begin
            item_next.cls = ais_pkg::CLASS_TERM;
        end
        else if (c >= ais_pkg::CHAR_ZERO && c <= ais_pkg::CHAR_NINE)
        begin
            item_next.cls   = ais_pkg::CLASS_DIGIT;
            item_next.digit = dec_val[3:0];
        end
        else if (cfg.hex_mode &&
                 ((c >= ais_pkg::CHAR_UPPER_A && c <= ais_pkg::CHAR_UPPER_F) ||
                  (c >= ais_pkg::CHAR_LOWER_A && c <= ais_pkg::CHAR_LOWER_F)))
        begin
            item_next.cls   = ais_pkg::CLASS_DIGIT;
            item_next.digit = hex_val[3:0];
        end
        else if (c == ais_pkg::CHAR_MINUS && cfg.signed_mode && !cfg.hex_mode)
        begin
            item_next.cls = ais_pkg::CLASS_MINUS;
        end
        else
        begin
            item_next.cls = ais_pkg::CLASS_INVALID;
        end
    end

    assign in_stall   = valid_reg && push_stall;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

>>> design/ais_queue.sv
// ----------------------------------------------------------------------------
// ais_queue
// Short request queue between the classifier and the accumulator.
// ----------------------------------------------------------------------------
module ais_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_stall,
    input  ais_pkg::qitem_t push_item,
    output logic            pop_valid,
    input  logic            pop_en,
    output ais_pkg::qitem_t pop_item
);

    ais_pkg::qitem_t                 slot_reg [ais_pkg::QUEUE_DEPTH];
    logic [ais_pkg::QPTR_BITS-1:0]   wr_ptr_reg;
    logic [ais_pkg::QPTR_BITS-1:0]   rd_ptr_reg;
    logic [ais_pkg::QPTR_BITS:0]     fill_reg;
    logic                            do_push;
    logic                            do_pop;

    assign push_stall = (fill_reg == (ais_pkg::QPTR_BITS+1)'(ais_pkg::QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && !push_stall;
    assign do_pop     = pop_en && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> design/ais_back.sv
// ----------------------------------------------------------------------------
// ais_back
// Accumulates classified characters and shapes the result into the output
// register.
// ----------------------------------------------------------------------------
module ais_back
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ais_pkg::cfg_t      cfg,
    input  logic               pop_valid,
    output logic               pop_en,
    input  ais_pkg::qitem_t    pop_item,
    output logic               out_valid,
    input  logic               out_stall,
    output ais_pkg::out_item_t out_data
);

    localparam int VB = ais_pkg::VALUE_BITS;
    localparam int CB = ais_pkg::CONSUMED_BITS;

    logic [VB-1:0]         acc_reg;
    logic [VB-1:0]         acc_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  ended_reg;
    logic                  ended_next;
    logic                  pend_reg;
    logic                  out_valid_reg;
    ais_pkg::out_item_t    out_item_reg;

    logic                  advance;
    logic                  do_pop;
    logic [VB-1:0]         acc_base;
    logic                  neg_base;
    logic [COUNT_BITS-1:0] count_base;
    logic                  ended_base;
    logic [COUNT_BITS-1:0] count_inc;
    logic [VB-1:0]         scaled;

    logic                  sgn;
    logic [VB-1:0]         mag;
    logic [VB-1:0]         shaped;
    logic [CB-1:0]         consumed;

    assign advance = !out_valid_reg || !out_stall;
    assign do_pop  = pop_valid && advance;
    assign pop_en  = advance;

    // start flag clears the state before the character is applied
    assign acc_base   = pop_item.start ? '0   : acc_reg;
    assign neg_base   = pop_item.start ? 1'b0 : neg_reg;
    assign count_base = pop_item.start ? '0   : count_reg;
    assign ended_base = pop_item.start ? 1'b0 : ended_reg;

    assign count_inc = (&count_base) ? count_base : count_base + 1'b1;
    assign scaled    = cfg.hex_mode ? {acc_base[VB-5:0], 4'd0}
                                    : {acc_base[VB-4:0], 3'd0} + {acc_base[VB-2:0], 1'b0};

    always_comb
    begin
        acc_next   = acc_base;
        neg_next   = neg_base;
        count_next = count_base;
        ended_next = ended_base;
        if (!ended_base)
        begin
            unique case (pop_item.cls)
                ais_pkg::CLASS_TERM:
                begin
                    ended_next = 1'b1;
                end
                ais_pkg::CLASS_DIGIT:
                begin
                    acc_next   = scaled + VB'(pop_item.digit);
                    count_next = count_inc;
                end
                ais_pkg::CLASS_MINUS:
                begin
                    if (count_base == '0 && !neg_base)
                    begin
                        neg_next   = 1'b1;
                        count_next = count_inc;
                    end
                    else
                    begin
                        ended_next = 1'b1;
                    end
                end
                default:
                begin
                    ended_next = 1'b1;
                end
            endcase
        end
    end

    // output shaping from the committed state
    assign sgn = cfg.signed_mode && !cfg.hex_mode;
    assign mag = neg_reg ? (VB'(0) - acc_reg) : acc_reg;

    always_comb
    begin
        shaped = mag;
        unique case (cfg.width_mode)
            ais_pkg::WIDTH_FULL:
            begin
                shaped = mag;
            end
            ais_pkg::WIDTH_TRUNC32:
            begin
                shaped = {{(VB-32){sgn && mag[31]}}, mag[31:0]};
            end
            ais_pkg::WIDTH_TRUNC16:
            begin
                shaped = {{(VB-16){sgn && mag[15]}}, mag[15:0]};
            end
            default:
            begin
                if (sgn)
                begin
                    if (mag[VB-1])
                    begin
                        if (!(&mag[VB-1:31]))
                        begin
                            shaped = {{(VB-31){1'b1}}, 31'd0};
                        end
                    end
                    else if (|mag[VB-2:31])
                    begin
                        shaped = {{(VB-31){1'b0}}, {31{1'b1}}};
                    end
                end
                else if (|mag[VB-1:32])
                begin
                    shaped = {{(VB-32){1'b0}}, {32{1'b1}}};
                end
            end
        endcase
    end

    generate
        if (COUNT_BITS > CB)
        begin : g_count_wide
            assign consumed = (|count_reg[COUNT_BITS-1:CB]) ? {CB{1'b1}} : count_reg[CB-1:0];
        end
        else
        begin : g_count_narrow
            assign consumed = CB'(count_reg);
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            count_reg     <= '0;
            ended_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            pend_reg      <= do_pop;
            out_valid_reg <= pend_reg;
            if (do_pop)
            begin
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                count_reg <= count_next;
                ended_reg <= ended_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && pend_reg)
        begin
            out_item_reg.value    <= shaped;
            out_item_reg.consumed <= consumed;
            out_item_reg.finished <= ended_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

>>> design/ascii_integer_scanner_core.sv
// ----------------------------------------------------------------------------
// ascii_integer_scanner_core
// Streaming ASCII decimal/hex to integer converter, one result per character.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle unless out_stall backs up the queue;
//   the accumulator's shift-add is combinational, so requests follow back to back.
// Path: an accepted character passes the classifier register, the queue,
//   the state update and the output register before out_valid rises.
// Reset: rst_n clears the scan state, queue, pipeline valids and the
//   configuration registers (decimal, unsigned, full width).
// ----------------------------------------------------------------------------
module ascii_integer_scanner_core
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [1:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  ais_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output ais_pkg::out_item_t out_data
);

    ais_pkg::cfg_t   cfg_reg;
    logic            push_valid;
    logic            push_stall;
    ais_pkg::qitem_t push_item;
    logic            pop_valid;
    logic            pop_en;
    ais_pkg::qitem_t pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ais_pkg::REG_HEX_MODE:    cfg_reg.hex_mode    <= cfg_data[0];
                ais_pkg::REG_SIGNED_MODE: cfg_reg.signed_mode <= cfg_data[0];
                ais_pkg::REG_WIDTH_MODE:  cfg_reg.width_mode  <= cfg_data;
                default:                  cfg_reg             <= cfg_reg;
            endcase
        end
    end

    ais_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_stall (push_stall),
        .push_item  (push_item)
    );

    ais_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_stall (push_stall),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_en     (pop_en),
        .pop_item   (pop_item)
    );

    ais_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .pop_valid  (pop_valid),
        .pop_en     (pop_en),
        .pop_item   (pop_item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

>>> verif/tb_ascii_integer_scanner_core.sv
// ----------------------------------------------------------------------------
// tb_ascii_integer_scanner_core
// Self-checking bench for the streaming ASCII-to-integer scanner. Character
// requests are tracked by a scan predictor that keeps its own accumulator,
// sign, count and end state. Each result is checked field by field against the
// oldest prediction. A directed run comes first. Random strings follow under
// random register settings, with sender and receiver stalls and a long
// receiver hold-off.
// ----------------------------------------------------------------------------
module tb_ascii_integer_scanner_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;

    class scan_checker;
        logic                              hex;
        logic                              sgn;
        logic [1:0]                        wmode;
        logic [ais_pkg::VALUE_BITS-1:0]    acc;
        logic                              neg;
        logic                              ended;
        logic [ais_pkg::CONSUMED_BITS-1:0] count;
        ais_pkg::out_item_t                pending_scans[$];
        int                                errors;

        function new();
            hex    = 1'b0;
            sgn    = 1'b0;
            wmode  = ais_pkg::WIDTH_FULL;
            acc    = '0;
            neg    = 1'b0;
            ended  = 1'b0;
            count  = '0;
            errors = 0;
        endfunction

        function void set_config(input logic h, input logic s, input logic [1:0] w);
            hex   = h;
            sgn   = s;
            wmode = w;
        endfunction

        function logic [ais_pkg::VALUE_BITS-1:0] shaped_value();
            logic                           is_signed;
            logic [ais_pkg::VALUE_BITS-1:0] v;
            is_signed = sgn && !hex;
            v = neg ? (64'd0 - acc) : acc;
            case (wmode)
                ais_pkg::WIDTH_TRUNC32:
                begin
                    v = {32'd0, v[31:0]};
                    if (is_signed && v[31])
                        v[63:32] = '1;
                end
                ais_pkg::WIDTH_TRUNC16:
                begin
                    v = {48'd0, v[15:0]};
                    if (is_signed && v[15])
                        v[63:16] = '1;
                end
                ais_pkg::WIDTH_SAT32:
                begin
                    if (is_signed)
                    begin
                        if (v[63])
                        begin
                            if (v < 64'hFFFF_FFFF_8000_0000)
                                v = 64'hFFFF_FFFF_8000_0000;
                        end
                        else if (v > 64'h0000_0000_7FFF_FFFF)
                            v = 64'h0000_0000_7FFF_FFFF;
                    end
                    else if (v > 64'h0000_0000_FFFF_FFFF)
                        v = 64'h0000_0000_FFFF_FFFF;
                end
                default: ;
            endcase
            return v;
        endfunction

        function void note_request(input ais_pkg::in_item_t req);
            logic [7:0]         c;
            logic [3:0]         dval;
            logic               is_digit;
            ais_pkg::out_item_t res;
            c        = req.char_code;
            dval     = '0;
            is_digit = 1'b0;
            if (req.start_of_string)
            begin
                acc   = '0;
                neg   = 1'b0;
                count = '0;
                ended = 1'b0;
            end
            if (c >= ais_pkg::CHAR_ZERO && c <= ais_pkg::CHAR_NINE)
            begin
                is_digit = 1'b1;
                dval     = 4'(c - ais_pkg::CHAR_ZERO);
            end
            else if (hex && c >= ais_pkg::CHAR_UPPER_A && c <= ais_pkg::CHAR_UPPER_F)
            begin
                is_digit = 1'b1;
                dval     = 4'(c - ais_pkg::CHAR_UPPER_A + 8'd10);
            end
            else if (hex && c >= ais_pkg::CHAR_LOWER_A && c <= ais_pkg::CHAR_LOWER_F)
            begin
                is_digit = 1'b1;
                dval     = 4'(c - ais_pkg::CHAR_LOWER_A + 8'd10);
            end
            if (!ended)
            begin
                if (c == ais_pkg::CHAR_NUL)
                    ended = 1'b1;
                else if (is_digit)
                begin
                    acc = acc * (hex ? 64'd16 : 64'd10) + {60'd0, dval};
                    if (count != '1)
                        count = count + 1'b1;
                end
                else if (c == ais_pkg::CHAR_MINUS && count == '0 && !neg && sgn && !hex)
                begin
                    neg = 1'b1;
                    if (count != '1)
                        count = count + 1'b1;
                end
                else
                    ended = 1'b1;
            end
            res.value    = shaped_value();
            res.consumed = count;
            res.finished = ended;
            pending_scans.push_back(res);
        endfunction

        function void report(input string field, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
            errors++;
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, exp_v, got_v);
        endfunction

        function void check_result(input ais_pkg::out_item_t got);
            ais_pkg::out_item_t exp_r;
            if (pending_scans.size() == 0)
            begin
                errors++;
                $error("result with no request outstanding: value 0x%0h", got.value);
                return;
            end
            exp_r = pending_scans.pop_front();
            if (got.value !== exp_r.value)
                report("value", exp_r.value, got.value);
            if (got.consumed !== exp_r.consumed)
                report("consumed", 64'(exp_r.consumed), 64'(got.consumed));
            if (got.finished !== exp_r.finished)
                report("finished", 64'(exp_r.finished), 64'(got.finished));
        endfunction

        function int pending();
            return pending_scans.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [1:0]         cfg_data;
    logic               in_valid;
    logic               in_stall;
    ais_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_stall;
    ais_pkg::out_item_t out_data;

    scan_checker sb = new();

    int   send_pct    = 24;
    int   recv_pct    = 47;
    int   hold_cycles = 0;
    int   sent        = 0;
    int   quiet       = 0;
    logic cur_hex     = 1'b0;
    logic cur_sgn     = 1'b0;

    ascii_integer_scanner_core u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // receiver: random stalls, or a counted hold-off when one is asked for
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_request(in_data);
            if (out_valid && !out_stall)
                sb.check_result(out_data);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet = quiet + 1;
            if (quiet >= STALL_LIMIT)
            begin
                $display("ascii_integer_scanner_core test failed");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [7:0] c, input logic s);
        @(negedge clk);
        while ($urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{char_code: c, start_of_string: s};
        do
            @(posedge clk);
        while (in_stall);
        sent++;
    endtask

    task automatic stop_sending();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic settle();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic apply_cfg(input logic h, input logic s, input logic [1:0] w);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= ais_pkg::REG_HEX_MODE;
        cfg_data  <= {1'b0, h};
        @(negedge clk);
        cfg_index <= ais_pkg::REG_SIGNED_MODE;
        cfg_data  <= {1'b0, s};
        @(negedge clk);
        cfg_index <= ais_pkg::REG_WIDTH_MODE;
        cfg_data  <= w;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_config(h, s, w);
        cur_hex = h;
        cur_sgn = s;
    endtask

    task automatic reconfigure(input logic h, input logic s, input logic [1:0] w);
        stop_sending();
        settle();
        apply_cfg(h, s, w);
    endtask

    function automatic logic [7:0] pick_digit(input logic h);
        int k;
        k = h ? $urandom_range(21) : $urandom_range(9);
        if (k < 10)
            return ais_pkg::CHAR_ZERO + 8'(k);
        if (k < 16)
            return ais_pkg::CHAR_LOWER_A + 8'(k - 10);
        return ais_pkg::CHAR_UPPER_A + 8'(k - 16);
    endfunction

    task automatic send_random_string();
        int   len;
        int   r;
        logic first_start;
        r = $urandom_range(99);
        if (r < 12)
        begin
            len = $urandom_range(1, 8);
            repeat (len) send_item(8'($urandom_range(255)), ($urandom_range(3) == 0));
            return;
        end
        first_start = ($urandom_range(9) != 0);
        if ($urandom_range(99) < ((cur_sgn && !cur_hex) ? 40 : 5))
        begin
            send_item(ais_pkg::CHAR_MINUS, first_start);
            first_start = 1'b0;
        end
        r = $urandom_range(99);
        len = (r < 70) ? $urandom_range(0, 5) :
              (r < 90) ? $urandom_range(6, 12) : $urandom_range(13, 24);
        repeat (len)
        begin
            send_item(pick_digit(cur_hex), first_start);
            first_start = 1'b0;
        end
        r = $urandom_range(99);
        if (r < 55)
            send_item(ais_pkg::CHAR_NUL, first_start);
        else if (r < 80)
            send_item(8'($urandom_range(255)), first_start);
        if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 3)) send_item(8'($urandom_range(255)), 1'b0);
    endtask

    initial
    begin
        int ph;
        int goal;
        int seg_goal;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = ais_pkg::REG_HEX_MODE;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_stall = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset defaults, no start flag on the first character
        send_item("7", 1'b0);
        send_item("9", 1'b0);
        send_item(ais_pkg::CHAR_NUL, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(ais_pkg::CHAR_MINUS, 1'b1);

        // lone minus, then a minus after a digit
        reconfigure(1'b0, 1'b1, ais_pkg::WIDTH_SAT32);
        send_item(ais_pkg::CHAR_MINUS, 1'b1);
        send_item(ais_pkg::CHAR_NUL, 1'b0);
        send_item(ais_pkg::CHAR_MINUS, 1'b1);
        send_item("5", 1'b0);
        send_item(ais_pkg::CHAR_MINUS, 1'b0);
        send_item("3", 1'b0);

        // hex: minus rejected, both letter cases, string left open
        reconfigure(1'b1, 1'b1, ais_pkg::WIDTH_TRUNC16);
        send_item(ais_pkg::CHAR_MINUS, 1'b1);
        send_item("f", 1'b1);
        send_item("F", 1'b0);
        send_item("a", 1'b0);
        send_item("A", 1'b0);
        send_item("9", 1'b0);

        // registers change mid-string
        reconfigure(1'b0, 1'b1, ais_pkg::WIDTH_TRUNC32);
        send_item("0", 1'b0);
        send_item(ais_pkg::CHAR_MINUS, 1'b0);
        send_item("G", 1'b0);

        for (ph = 0; ph < 3; ph++)
        begin
            send_pct = (ph == 0) ? 24 : (ph == 1) ? 47 : 0;
            recv_pct = (ph == 0) ? 47 : (ph == 1) ? 24 : 0;
            goal = sent + 640;
            reconfigure(1'($urandom_range(1)), 1'($urandom_range(1)),
                        2'($urandom_range(3)));
            hold_cycles = 80;
            while (sent < goal)
            begin
                seg_goal = sent + $urandom_range(30, 90);
                while (sent < seg_goal)
                    send_random_string();
                reconfigure(1'($urandom_range(1)), 1'($urandom_range(1)),
                            2'($urandom_range(3)));
            end
        end

        stop_sending();
        settle();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ascii_integer_scanner_core test passed");
        else
            $display("ascii_integer_scanner_core test failed");
        $finish;
    end

endmodule

>>> sim.f
design/ais_pkg.sv
design/ais_front.sv
design/ais_queue.sv
design/ais_back.sv
design/ascii_integer_scanner_core.sv
verif/tb_ascii_integer_scanner_core.sv
